// File: src/assert_macros.svh
// Assertion macros used by the controller (wfc_ctrl) of the waveform classifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk_i while rst_ni is high.
`define WFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks a property on every rising edge of clk_i, also during reset.
`define WFC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: src/wfc_pkg.sv
package wfc_pkg;

  // Sample and result field widths.
  localparam int SAMPLE_BITS    = 10;
  localparam int SHAPE_W        = 3;
  localparam int PEAK_W         = 16;
  localparam int DIFF_W         = 16;

  // Configuration registers.
  localparam int WL_W           = 7;
  localparam int MARGIN_W       = 10;
  localparam int WL_RESET       = 18;
  localparam int MARGIN_RESET   = 2;
  localparam int MIN_WINDOW     = 4;
  localparam int DEF_MAX_WINDOW = 64;
  localparam int CFG_IDX_W      = 4;
  localparam int CFG_DATA_W     = 10;

  // Conversion of ADC counts to millivolts.
  localparam int MV_FULL_SCALE  = 5000;
  localparam int ADC_COUNTS     = 1024;
  localparam int ADC_SHIFT      = $clog2(ADC_COUNTS);
  localparam int SAW_GAIN       = 20;
  localparam int TRI_GAIN       = 10;
  localparam int SCALE_W        = $clog2(SAW_GAIN * MV_FULL_SCALE + 1);

  typedef enum logic [SHAPE_W-1:0] {
    SHAPE_SQUARE = 3'd0,
    SHAPE_RISE   = 3'd1,
    SHAPE_FALL   = 3'd2,
    SHAPE_TRI    = 3'd3,
    SHAPE_SINE   = 3'd4,
    SHAPE_UNDEF  = 3'd5
  } shape_e;

  typedef enum logic [1:0] {
    SLOPE_UP   = 2'd0,
    SLOPE_DOWN = 2'd1,
    SLOPE_FLAT = 2'd2
  } slope_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LENGTH = 4'd0,
    REG_SLOPE_MARGIN  = 4'd1
  } cfg_reg_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic mul_en;
    logic div_start;
    logic load_out;
  } wfc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
    logic div_busy;
    logic div_done;
  } wfc_sts_t;

endpackage

// File: src/wfc_if.sv
// Sample input channel.
interface wfc_sample_if import wfc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// Classification result channel.
interface wfc_result_if import wfc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SHAPE_W-1:0] shape;
  logic [PEAK_W-1:0]  peak_millivolts;

  modport source (output valid, output shape, output peak_millivolts, input ready);
  modport sink (input valid, input shape, input peak_millivolts, output ready);
endinterface

// Configuration write channel.
interface wfc_cfg_if import wfc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/wfc_divider.sv
module wfc_divider import wfc_pkg::*; #(
  parameter int DVD_W = 24,
  parameter int DVS_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] divisor_q;
  logic [DVS_W:0]   trial;
  logic             fits;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    trial = {rem_q, quo_q[DVD_W-1]};
    fits  = trial >= {1'b0, divisor_q};
    if (fits) begin
      rem_d = DVS_W'(trial - {1'b0, divisor_q});
    end else begin
      rem_d = trial[DVS_W-1:0];
    end
    quo_d = {quo_q[DVD_W-2:0], fits};
  end

  // Step counter and handshake flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(DVD_W);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q     <= '0;
      quo_q     <= dividend_i;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: src/wfc_datapath.sv
module wfc_datapath import wfc_pkg::*; #(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  wfc_cmd_t               cmd_i,
  output wfc_sts_t               sts_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   cfg_wr_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output logic [SHAPE_W-1:0]     shape_o,
  output logic [PEAK_W-1:0]      peak_o
);

  localparam int POS_W  = $clog2(MAX_WINDOW);
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int LEN_W  = (CNT_W > WL_W) ? CNT_W : WL_W;
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int PROD_W = SUM_W + SCALE_W;
  localparam int QUO_W  = PROD_W - ADC_SHIFT;

  // Configuration registers.
  logic [WL_W-1:0]     wl_q;
  logic [MARGIN_W-1:0] margin_q;

  // Window state.
  logic [POS_W-1:0]       pos_q, pos_d;
  logic [SAMPLE_BITS-1:0] first_q, first_d;
  logic [SAMPLE_BITS-1:0] prev_q, prev_d;
  logic [SAMPLE_BITS-1:0] third_q, third_d;
  logic [DIFF_W-1:0]      early_q, early_d;
  slope_e                 init_q, init_d;
  logic                   fell_q, fell_d;
  logic                   undef_q, undef_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic                   turn_q, turn_d;
  logic [POS_W-1:0]       turnpos_q, turnpos_d;
  logic [SAMPLE_BITS-1:0] top0_q, top0_d;
  logic [SAMPLE_BITS-1:0] top1_q, top1_d;
  logic                   accel_q, accel_d;

  // Operands of the end-of-window conversion.
  shape_e                 fin_shape_q, fin_shape_d;
  logic [SUM_W-1:0]       fin_amount_q, fin_amount_d;
  logic [SCALE_W-1:0]     fin_scale_q, fin_scale_d;
  logic [CNT_W-1:0]       fin_count_q, fin_count_d;
  logic [PROD_W-1:0]      product_q;

  // Result register.
  logic [SHAPE_W-1:0]     shape_q;
  logic [PEAK_W-1:0]      peak_q;

  logic [LEN_W-1:0]       wl_ext, len_eff, pos_next;
  logic                   last;
  logic [SAMPLE_BITS:0]   prev_plus, s_plus;
  slope_e                 step;
  logic [DIFF_W-1:0]      d3;
  logic                   div_busy, div_done;
  logic [QUO_W-1:0]       quotient;
  logic [PEAK_W-1:0]      peak_sat;

  // Effective window length, clamped to the supported range.
  always_comb begin
    wl_ext = LEN_W'(wl_q);
    if (wl_ext < LEN_W'(MIN_WINDOW)) begin
      len_eff = LEN_W'(MIN_WINDOW);
    end else if (wl_ext > LEN_W'(MAX_WINDOW)) begin
      len_eff = LEN_W'(MAX_WINDOW);
    end else begin
      len_eff = wl_ext;
    end
    pos_next = LEN_W'(pos_q) + 1'b1;
    last     = pos_next >= len_eff;
  end

  // Classify the step from the previous sample to the new one.
  always_comb begin
    prev_plus = (SAMPLE_BITS + 1)'(prev_q) + (SAMPLE_BITS + 1)'(margin_q);
    s_plus    = (SAMPLE_BITS + 1)'(sample_i) + (SAMPLE_BITS + 1)'(margin_q);
    if ((SAMPLE_BITS + 1)'(sample_i) > prev_plus) begin
      step = SLOPE_UP;
    end else if (s_plus < (SAMPLE_BITS + 1)'(prev_q)) begin
      step = SLOPE_DOWN;
    end else begin
      step = SLOPE_FLAT;
    end
    d3 = DIFF_W'(sample_i) - DIFF_W'(third_q);
  end

  // Window update for an accepted sample, and the conversion operands
  // at the end of a window.
  always_comb begin
    pos_d        = pos_q;
    first_d      = first_q;
    prev_d       = prev_q;
    third_d      = third_q;
    early_d      = early_q;
    init_d       = init_q;
    fell_d       = fell_q;
    undef_d      = undef_q;
    sum_d        = sum_q;
    turn_d       = turn_q;
    turnpos_d    = turnpos_q;
    top0_d       = top0_q;
    top1_d       = top1_q;
    accel_d      = accel_q;
    fin_shape_d  = fin_shape_q;
    fin_amount_d = fin_amount_q;
    fin_scale_d  = fin_scale_q;
    fin_count_d  = fin_count_q;

    if (cmd_i.accept) begin
      if (pos_q == '0) begin
        first_d = sample_i;
      end else begin
        if (pos_q == POS_W'(1)) begin
          init_d  = step;
          early_d = DIFF_W'(sample_i) - DIFF_W'(first_q);
        end else if (pos_q == POS_W'(2)) begin
          third_d = sample_i;
        end else if (pos_q == POS_W'(3)) begin
          accel_d = (DIFF_W + 1)'(early_q) > ((DIFF_W + 1)'(d3) + (DIFF_W + 1)'(margin_q));
        end

        // Shape tracking; a sample near zero spoils the window.
        if (sample_i <= margin_q) begin
          undef_d = 1'b1;
        end else if (!undef_q) begin
          if (init_d == SLOPE_UP) begin
            if (step == SLOPE_DOWN) begin
              fell_d = 1'b1;
              if (!turn_q) begin
                turn_d    = 1'b1;
                turnpos_d = pos_q;
                top0_d    = prev_q;
                top1_d    = sample_i;
              end
            end else if (step != SLOPE_UP || fell_q) begin
              undef_d = 1'b1;
            end
          end else if (step != init_d) begin
            undef_d = 1'b1;
          end
        end
      end
      prev_d = sample_i;
      sum_d  = sum_q + SUM_W'(sample_i);

      if (!last) begin
        pos_d = pos_q + 1'b1;
      end else begin
        // Pick the shape and the operands of amount * scale / (1024 * count).
        fin_count_d = CNT_W'(pos_q);
        if (undef_d) begin
          fin_shape_d  = SHAPE_UNDEF;
          fin_amount_d = '0;
          fin_scale_d  = '0;
          fin_count_d  = CNT_W'(1);
        end else if (init_d == SLOPE_FLAT) begin
          fin_shape_d  = SHAPE_SQUARE;
          fin_amount_d = sum_d;
          fin_scale_d  = SCALE_W'(MV_FULL_SCALE);
          fin_count_d  = CNT_W'(pos_next);
        end else if (init_d == SLOPE_DOWN) begin
          fin_shape_d  = SHAPE_FALL;
          fin_amount_d = SUM_W'(first_d - sample_i);
          fin_scale_d  = SCALE_W'(SAW_GAIN * MV_FULL_SCALE);
        end else if (!fell_d) begin
          fin_shape_d  = SHAPE_RISE;
          fin_amount_d = SUM_W'(sample_i - first_d);
          fin_scale_d  = SCALE_W'(SAW_GAIN * MV_FULL_SCALE);
        end else if (accel_d) begin
          fin_shape_d  = SHAPE_SINE;
          fin_amount_d = SUM_W'(top0_d);
          fin_scale_d  = SCALE_W'(MV_FULL_SCALE);
          fin_count_d  = CNT_W'(1);
        end else begin
          fin_shape_d  = SHAPE_TRI;
          fin_amount_d = SUM_W'(top1_d - sample_i);
          fin_scale_d  = SCALE_W'(TRI_GAIN * MV_FULL_SCALE);
          fin_count_d  = CNT_W'(pos_next) - CNT_W'(turnpos_d);
        end

        // Start a fresh window.
        pos_d     = '0;
        first_d   = '0;
        prev_d    = '0;
        third_d   = '0;
        early_d   = '0;
        init_d    = SLOPE_UP;
        fell_d    = 1'b0;
        undef_d   = 1'b0;
        sum_d     = '0;
        turn_d    = 1'b0;
        turnpos_d = '0;
        top0_d    = '0;
        top1_d    = '0;
        accel_d   = 1'b0;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q     <= WL_W'(WL_RESET);
      margin_q <= MARGIN_W'(MARGIN_RESET);
    end else if (cfg_wr_i) begin
      unique case (cfg_index_i)
        REG_WINDOW_LENGTH: wl_q <= cfg_data_i[WL_W-1:0];
        REG_SLOPE_MARGIN:  margin_q <= cfg_data_i[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Window state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      first_q   <= '0;
      prev_q    <= '0;
      third_q   <= '0;
      early_q   <= '0;
      init_q    <= SLOPE_UP;
      fell_q    <= 1'b0;
      undef_q   <= 1'b0;
      sum_q     <= '0;
      turn_q    <= 1'b0;
      turnpos_q <= '0;
      top0_q    <= '0;
      top1_q    <= '0;
      accel_q   <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      first_q   <= first_d;
      prev_q    <= prev_d;
      third_q   <= third_d;
      early_q   <= early_d;
      init_q    <= init_d;
      fell_q    <= fell_d;
      undef_q   <= undef_d;
      sum_q     <= sum_d;
      turn_q    <= turn_d;
      turnpos_q <= turnpos_d;
      top0_q    <= top0_d;
      top1_q    <= top1_d;
      accel_q   <= accel_d;
    end
  end

  // Conversion operands, product and result registers.
  always_ff @(posedge clk_i) begin
    fin_shape_q  <= fin_shape_d;
    fin_amount_q <= fin_amount_d;
    fin_scale_q  <= fin_scale_d;
    fin_count_q  <= fin_count_d;
    if (cmd_i.mul_en) begin
      product_q <= PROD_W'(fin_amount_q) * PROD_W'(fin_scale_q);
    end
    if (cmd_i.load_out) begin
      shape_q <= fin_shape_q;
      peak_q  <= peak_sat;
    end
  end

  // The divide by 1024 is a shift; the divide by the count is iterative.
  wfc_divider #(
    .DVD_W(QUO_W),
    .DVS_W(CNT_W)
  ) u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(product_q[PROD_W-1:ADC_SHIFT]),
    .divisor_i (fin_count_q),
    .busy_o    (div_busy),
    .done_o    (div_done),
    .quotient_o(quotient)
  );

  // Saturate the quotient to the peak field.
  always_comb begin
    if (|quotient[QUO_W-1:PEAK_W]) begin
      peak_sat = '1;
    end else begin
      peak_sat = quotient[PEAK_W-1:0];
    end
  end

  assign sts_o.last     = last;
  assign sts_o.div_busy = div_busy;
  assign sts_o.div_done = div_done;
  assign shape_o        = shape_q;
  assign peak_o         = peak_q;

endmodule

// File: src/wfc_ctrl.sv
`include "assert_macros.svh"

module wfc_ctrl import wfc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  wfc_sts_t sts_i,
  output wfc_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_SAMPLE,
    ST_MUL,
    ST_START,
    ST_DIV,
    ST_OUTPUT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   in_ready;
  logic   out_free;

  // Samples are taken only between windows' conversions.
  assign in_ready = (state_q == ST_SAMPLE);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o.accept    = in_valid_i && in_ready;
    cmd_o.mul_en    = (state_q == ST_MUL);
    cmd_o.div_start = (state_q == ST_START);
    cmd_o.load_out  = (state_q == ST_OUTPUT) && out_free;
  end

  // State sequence and the output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SAMPLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_SAMPLE: begin
          if (cmd_o.accept && sts_i.last) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          state_q <= ST_START;
        end
        ST_START: begin
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (sts_i.div_done) begin
            state_q <= ST_OUTPUT;
          end
        end
        ST_OUTPUT: begin
          if (out_free) begin
            state_q <= ST_SAMPLE;
          end
        end
        default: state_q <= ST_SAMPLE;
      endcase
    end
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;

  `WFC_ASSERT(a_no_sample_during_divide, sts_i.div_busy |-> !in_ready_o, "sample taken while dividing")
  `WFC_ASSERT(a_load_into_free_slot, cmd_o.load_out |-> (!out_valid_q || out_ready_i), "result overwritten")
  `WFC_ASSERT_ALWAYS(a_done_only_in_divide, sts_i.div_done |-> (state_q == ST_DIV), "stray divider done")
  `WFC_ASSERT(a_load_raises_valid, cmd_o.load_out |=> out_valid_q, "loaded result not offered")

endmodule

// File: src/waveform_shape_classifier.sv
// Waveform shape classifier. Feed one 10-bit ADC sample per transfer; after
// the configured number of samples (window_length, clamped to 4..MAX_WINDOW)
// the block offers one result with the shape code (square, rising saw,
// falling saw, triangle, sine or undefined) and a peak estimate in
// millivolts, saturated at 65535, then starts the next window. Every sample
// but the last of a window is taken as soon as it is offered. The last
// sample starts the peak conversion: a multiply, a load of the divider, then
// a restoring divider by the sample count that retires one quotient bit per
// cycle (17 + clog2(MAX_WINDOW+1) bits, 24 at the default MAX_WINDOW of 64),
// the divider's done flag and the write of the result register. The next
// sample is taken only after that write.
// The result register holds one finished result while the next window is
// collected; if it is still full when the next conversion ends, the block
// waits for the result transfer.
// Configuration writes are always accepted and must be made while idle.
module waveform_shape_classifier import wfc_pkg::*; #(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  wfc_sample_if.sink   sample_ch,
  wfc_result_if.source result_ch,
  wfc_cfg_if.sink      cfg_ch
);

  wfc_cmd_t cmd;
  wfc_sts_t sts;

  // Sequencing of sample intake, conversion and result hand-off.
  wfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_ch.valid),
    .in_ready_o (sample_ch.ready),
    .out_valid_o(result_ch.valid),
    .out_ready_i(result_ch.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Window tracking, peak arithmetic and registers.
  wfc_datapath #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .sample_i   (sample_ch.sample),
    .cfg_wr_i   (cfg_ch.valid),
    .cfg_index_i(cfg_ch.index),
    .cfg_data_i (cfg_ch.data),
    .shape_o    (result_ch.shape),
    .peak_o     (result_ch.peak_millivolts)
  );

  // Configuration writes complete in the cycle they are offered.
  assign cfg_ch.ready = 1'b1;

endmodule
